// File: sv/esd_pkg.sv
package esd_pkg;

  localparam int unsigned ACC_MAX_W   = 64;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned DEF_VALUE_W = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [VALUE_W-1:0] LIMIT_RESET = 32'd255;

  // register word index (paddr[2])
  localparam logic REG_VALUE_LIMIT = 1'b0;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_OCT  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK           = 2'd0,
    ERR_INV_PRINT    = 2'd1,
    ERR_INV_NONPRINT = 2'd2,
    ERR_CLAMPED      = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    WARN_NONE  = 2'd0,
    WARN_SHORT = 2'd1,
    WARN_LONG  = 2'd2
  } warn_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    err_t               err;
    warn_t              warn;
    logic               consumed;
  } res_t;

  // {is_hex, digit}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic err_t invalid_err(input logic [7:0] c);
    return (c >= 8'h20 && c <= 8'h7e) ? ERR_INV_PRINT : ERR_INV_NONPRINT;
  endfunction

endpackage

// File: sv/escape_sequence_decoder.sv
// C escape sequence decoder.
// Input channel (in_valid/in_stall): one byte per request in ch; start_req
// marks the byte right after a backslash. Output channel (out_valid/
// out_stall): value, error_code, octal_warning, byte_consumed. A byte gives
// at most one result: simple and invalid escapes answer on their own byte,
// hex and octal escapes answer on the first byte that does not extend them
// (reported with byte_consumed = 0, left for the caller).
// A request passes through the input register, then the decode step writes
// the result register.
// Throughput is one byte per cycle unless the output stalls; the decode step
// is a shift-insert and one compare on the accumulator.
// value_limit is written over the APB port (address 0) while the decoder is
// idle (the user's duty; the block does not enforce it); it resets to 255.
// Reset empties both registers and returns the decoder to idle.
// A stalled result holds; the input register still takes one more byte,
// after which in_stall rises until the result is taken.
module escape_sequence_decoder #(
  parameter int unsigned VALUE_WIDTH = esd_pkg::DEF_VALUE_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        ch,
  input  logic                              start_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [esd_pkg::VALUE_W-1:0]       value,
  output logic [1:0]                        error_code,
  output logic [1:0]                        octal_warning,
  output logic                              byte_consumed,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [esd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [esd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [esd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic                         s1_valid;
  logic [7:0]                   s1_ch;
  logic                         s1_start;
  logic                         can_load;
  logic                         advance;
  logic                         in_take;
  logic                         res_valid;
  esd_pkg::res_t                res;
  esd_pkg::res_t                out_res;
  logic [esd_pkg::VALUE_W-1:0]  value_limit;

  esd_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .value_limit (value_limit)
  );

  assign can_load = !out_valid || !out_stall;
  assign advance  = s1_valid && can_load;
  assign in_stall = s1_valid && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch    <= ch;
      s1_start <= start_req;
    end
  end

  esd_engine #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .ch          (s1_ch),
    .start       (s1_start),
    .value_limit (value_limit),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign value         = out_res.value;
  assign error_code    = out_res.err;
  assign octal_warning = out_res.warn;
  assign byte_consumed = out_res.consumed;

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_clamp_is_terminator: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == esd_pkg::ERR_CLAMPED) |-> !byte_consumed)
    else $error("clamped result claims its byte");

  a_warn_is_terminator: assert property (@(posedge clk) disable iff (rst)
    (out_valid && octal_warning != esd_pkg::WARN_NONE) |-> !byte_consumed)
    else $error("octal warning on a consumed byte");

  a_no_result_drops: assert property (@(posedge clk) disable iff (rst)
    (advance && !res_valid) |=> !out_valid)
    else $error("result invented for a byte without one");

endmodule

// File: sv/esd_apb.sv
module esd_apb (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [esd_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [esd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [esd_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  output logic [esd_pkg::VALUE_W-1:0]          value_limit
);

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = paddr[2] == esd_pkg::REG_VALUE_LIMIT;
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_limit <= esd_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      value_limit <= pwdata;
    end
  end

  assign prdata = hit ? value_limit : '0;

endmodule

// File: sv/esd_engine.sv
module esd_engine #(
  parameter int unsigned VALUE_WIDTH = esd_pkg::DEF_VALUE_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic [7:0]                    ch,
  input  logic                          start,
  input  logic [esd_pkg::VALUE_W-1:0]   value_limit,
  output logic                          res_valid,
  output esd_pkg::res_t                 res
);

  esd_pkg::mode_t           mode, mode_next;
  logic [VALUE_WIDTH-1:0]   acc, acc_next;
  logic [1:0]               digit_count, digit_count_next;
  logic                     overflowed, overflowed_next;

  logic [esd_pkg::ACC_MAX_W-1:0] lim_wide;
  logic [esd_pkg::ACC_MAX_W-1:0] lim_ext;
  logic [esd_pkg::ACC_MAX_W-1:0] acc_masked_wide;
  logic [VALUE_WIDTH-1:0]        lim;
  logic [VALUE_WIDTH-1:0]        acc_masked;
  logic [4:0]                    hex;

  assign lim_wide        = esd_pkg::ACC_MAX_W'(value_limit);
  assign lim             = lim_wide[VALUE_WIDTH-1:0];
  assign lim_ext         = esd_pkg::ACC_MAX_W'(lim);
  assign acc_masked      = acc & lim;
  assign acc_masked_wide = esd_pkg::ACC_MAX_W'(acc_masked);
  assign hex             = esd_pkg::hex_digit(ch);

  always_comb begin
    mode_next        = mode;
    acc_next         = acc;
    digit_count_next = digit_count;
    overflowed_next  = overflowed;
    res_valid        = 1'b0;
    res.value        = '0;
    res.err          = esd_pkg::ERR_OK;
    res.warn         = esd_pkg::WARN_NONE;
    res.consumed     = 1'b0;

    if (start) begin
      mode_next    = esd_pkg::MODE_IDLE;
      res_valid    = 1'b1;
      res.consumed = 1'b1;
      unique case (ch)
        "a": res.value = 32'd7;
        "b": res.value = 32'd8;
        "f": res.value = 32'd12;
        "n": res.value = 32'd10;
        "r": res.value = 32'd13;
        "t": res.value = 32'd9;
        "v": res.value = 32'd11;
        "'", "\"", "\\", "?": res.value = esd_pkg::VALUE_W'(ch);
        "x": begin
          mode_next        = esd_pkg::MODE_HEX;
          acc_next         = '0;
          digit_count_next = 2'd0;
          overflowed_next  = 1'b0;
          res_valid        = 1'b0;
        end
        default: begin
          if (esd_pkg::is_octal(ch)) begin
            mode_next        = esd_pkg::MODE_OCT;
            acc_next         = VALUE_WIDTH'(ch[2:0]);
            digit_count_next = 2'd1;
            overflowed_next  = 1'b0;
            res_valid        = 1'b0;
          end else begin
            res.value = esd_pkg::VALUE_W'(ch);
            res.err   = esd_pkg::invalid_err(ch);
          end
        end
      endcase
    end else begin
      unique case (mode)
        esd_pkg::MODE_HEX: begin
          if (hex[4]) begin
            if (!overflowed) begin
              // freeze once another digit would not fit under the limit
              if ((acc & ~(lim >> 4)) != '0) begin
                overflowed_next = 1'b1;
              end else begin
                acc_next = {acc[VALUE_WIDTH-5:0], hex[3:0]};
              end
            end
            digit_count_next = 2'd1;
          end else begin
            mode_next = esd_pkg::MODE_IDLE;
            res_valid = 1'b1;
            if (digit_count == 2'd0) begin
              res.err = esd_pkg::invalid_err(ch);
            end else if (overflowed) begin
              res.value = lim_ext[esd_pkg::VALUE_W-1:0];
              res.err   = esd_pkg::ERR_CLAMPED;
            end else begin
              res.value = acc_masked_wide[esd_pkg::VALUE_W-1:0];
            end
          end
        end
        esd_pkg::MODE_OCT: begin
          if (esd_pkg::is_octal(ch) && digit_count != esd_pkg::OCT_MAX_DIGITS) begin
            acc_next         = {acc[VALUE_WIDTH-4:0], ch[2:0]};
            digit_count_next = digit_count + 2'd1;
          end else begin
            mode_next = esd_pkg::MODE_IDLE;
            res_valid = 1'b1;
            if (esd_pkg::is_decimal(ch)) begin
              if (digit_count != esd_pkg::OCT_MAX_DIGITS && (ch == "8" || ch == "9")) begin
                res.warn = esd_pkg::WARN_SHORT;
              end else if (digit_count == esd_pkg::OCT_MAX_DIGITS) begin
                res.warn = esd_pkg::WARN_LONG;
              end
            end
            if (acc > lim) begin
              res.value = lim_ext[esd_pkg::VALUE_W-1:0];
              res.err   = esd_pkg::ERR_CLAMPED;
            end else begin
              res.value = acc_masked_wide[esd_pkg::VALUE_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= esd_pkg::MODE_IDLE;
      acc         <= '0;
      digit_count <= 2'd0;
      overflowed  <= 1'b0;
    end else if (advance) begin
      mode        <= mode_next;
      acc         <= acc_next;
      digit_count <= digit_count_next;
      overflowed  <= overflowed_next;
    end
  end

endmodule
